>>> rtl/core/cle_pkg.sv
`default_nettype none

package cle_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;

  // Readout tree: CAPACITY must be a power of two of at least 64
  localparam int GRP_W    = 5;
  localparam int SEL_W    = IDX_W - GRP_W;
  localparam int NGRP     = 1 << SEL_W;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [3:0] {
    MODE_CLEAR      = 4'd0,
    MODE_PREPEND    = 4'd1,
    MODE_APPEND     = 4'd2,
    MODE_INS_BEFORE = 4'd3,
    MODE_INS_AFTER  = 4'd4,
    MODE_DEL_FRONT  = 4'd5,
    MODE_DEL_BACK   = 4'd6,
    MODE_DEL_CURSOR = 4'd7,
    MODE_MOVE_TO    = 4'd8,
    MODE_PREV       = 4'd9,
    MODE_NEXT       = 4'd10
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] at;
    word_t            value;
  } shift_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/cursor_list_engine_unit.sv
`default_nettype none

// Channel | Direction | Handshake           | Word
// --------+-----------+---------------------+-------------------------------------------
// in      | to block  | in_valid / in_stall | mode, value, position
// out     | from block| out_valid / out_stall| status, front_value, back_value,
//         |           |                     | cursor_value, count, cursor_index
//
// One word in, one word out, one word at a time: the cell row shifts at the
// accepting edge, then the back and cursor reads pass a two-level select tree
// (32 groups of 32, first level registered) before landing in the output register.
// in_stall is high while a word is in the read tree or out_stall holds it there.
// Reset (rst, synchronous) empties the list and leaves the cursor undefined;
// cell contents are not reset.

module cursor_list_engine_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [3:0]                      mode,
  input  wire logic signed [cle_pkg::WORD_W-1:0] value,
  input  wire logic [9:0]                      position,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           status,
  output logic signed [cle_pkg::WORD_W-1:0]    front_value,
  output logic signed [cle_pkg::WORD_W-1:0]    back_value,
  output logic signed [cle_pkg::WORD_W-1:0]    cursor_value,
  output logic [cle_pkg::CNT_W-1:0]            count,
  output logic signed [cle_pkg::CNT_W-1:0]     cursor_index
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_GATHER,
    PH_DRIVE
  } phase_t;

  phase_t                      ph;
  logic [cle_pkg::CNT_W-1:0]   elem_count, elem_count_next;
  logic                        cur_ok, cur_ok_next;
  logic [cle_pkg::IDX_W-1:0]   cur_idx, cur_idx_next;
  cle_pkg::status_t            st, st_next;
  cle_pkg::shift_cmd_t         op_cmd, cell_cmd;

  logic                        accept, out_free;
  logic                        empty, full;
  logic [cle_pkg::CNT_W-1:0]   cur_ext, cur_inc;
  logic [cle_pkg::IDX_W-1:0]   back_idx;
  cle_pkg::word_t              row [cle_pkg::CAPACITY];
  cle_pkg::word_t              back_rd, cur_rd;

  assign in_stall = (ph != PH_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign empty    = (elem_count == '0);
  assign full     = (elem_count == cle_pkg::CNT_W'(cle_pkg::CAPACITY));
  assign cur_ext  = cle_pkg::CNT_W'(cur_idx);
  assign cur_inc  = cur_ext + cle_pkg::CNT_W'(1);
  assign back_idx = cle_pkg::IDX_W'(elem_count - cle_pkg::CNT_W'(1));

  always_comb begin
    elem_count_next = elem_count;
    cur_ok_next     = cur_ok;
    cur_idx_next    = cur_idx;
    st_next         = cle_pkg::ST_OK;
    op_cmd          = '{ins: 1'b0, del: 1'b0, at: '0, value: value};
    case (cle_pkg::mode_t'(mode))
      cle_pkg::MODE_CLEAR: begin
        elem_count_next = '0;
        cur_ok_next     = 1'b0;
      end
      cle_pkg::MODE_PREPEND: begin
        if (full) begin
          st_next = cle_pkg::ST_FULL;
        end else begin
          op_cmd.ins      = 1'b1;
          elem_count_next = elem_count + cle_pkg::CNT_W'(1);
          if (cur_ok) cur_idx_next = cle_pkg::IDX_W'(cur_inc);
        end
      end
      cle_pkg::MODE_APPEND: begin
        if (full) begin
          st_next = cle_pkg::ST_FULL;
        end else begin
          op_cmd.ins      = 1'b1;
          op_cmd.at       = cle_pkg::IDX_W'(elem_count);
          elem_count_next = elem_count + cle_pkg::CNT_W'(1);
        end
      end
      cle_pkg::MODE_INS_BEFORE: begin
        if (empty || !cur_ok) begin
          st_next = cle_pkg::ST_EMPTY;
        end else if (full) begin
          st_next = cle_pkg::ST_FULL;
        end else begin
          op_cmd.ins      = 1'b1;
          op_cmd.at       = cur_idx;
          elem_count_next = elem_count + cle_pkg::CNT_W'(1);
          cur_idx_next    = cle_pkg::IDX_W'(cur_inc);
        end
      end
      cle_pkg::MODE_INS_AFTER: begin
        // quietly skip with no cursor
        if (!empty && cur_ok) begin
          if (full) begin
            st_next = cle_pkg::ST_FULL;
          end else begin
            op_cmd.ins      = 1'b1;
            op_cmd.at       = cle_pkg::IDX_W'(cur_inc);
            elem_count_next = elem_count + cle_pkg::CNT_W'(1);
          end
        end
      end
      cle_pkg::MODE_DEL_FRONT: begin
        if (empty) begin
          st_next = cle_pkg::ST_EMPTY;
        end else begin
          op_cmd.del      = 1'b1;
          elem_count_next = elem_count - cle_pkg::CNT_W'(1);
          if (cur_ok) begin
            if (cur_idx == '0) cur_ok_next = 1'b0;
            else cur_idx_next = cur_idx - cle_pkg::IDX_W'(1);
          end
        end
      end
      cle_pkg::MODE_DEL_BACK: begin
        if (empty) begin
          st_next = cle_pkg::ST_EMPTY;
        end else begin
          op_cmd.del      = 1'b1;
          op_cmd.at       = back_idx;
          elem_count_next = elem_count - cle_pkg::CNT_W'(1);
          if (cur_ok && cur_idx == back_idx) cur_ok_next = 1'b0;
        end
      end
      cle_pkg::MODE_DEL_CURSOR: begin
        if (empty || !cur_ok) begin
          st_next = cle_pkg::ST_EMPTY;
        end else begin
          op_cmd.del      = 1'b1;
          op_cmd.at       = cur_idx;
          elem_count_next = elem_count - cle_pkg::CNT_W'(1);
          cur_ok_next     = 1'b0;
        end
      end
      cle_pkg::MODE_MOVE_TO: begin
        cur_ok_next  = (cle_pkg::CNT_W'(position) < elem_count);
        cur_idx_next = cle_pkg::IDX_W'(position);
      end
      cle_pkg::MODE_PREV: begin
        cur_ok_next  = cur_ok && (cur_idx != '0) && (cur_ext < elem_count);
        cur_idx_next = cur_idx - cle_pkg::IDX_W'(1);
      end
      cle_pkg::MODE_NEXT: begin
        cur_ok_next  = cur_ok && (cur_inc < elem_count);
        cur_idx_next = cle_pkg::IDX_W'(cur_inc);
      end
      default: begin
      end
    endcase
  end

  // Shift the row only at the accepting edge
  always_comb begin
    cell_cmd     = op_cmd;
    cell_cmd.ins = op_cmd.ins && accept;
    cell_cmd.del = op_cmd.del && accept;
  end

  for (genvar i = 0; i < cle_pkg::CAPACITY; i++) begin : g_cell
    cle_pkg::word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = row[i-1];
    end
    if (i == cle_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = row[i+1];
    end
    cle_cell u_cell (
      .clk   (clk),
      .cmd   (cell_cmd),
      .idx   (cle_pkg::IDX_W'(i)),
      .left  (left_w),
      .right (right_w),
      .data  (row[i])
    );
  end

  cle_row_read u_back_read (
    .clk     (clk),
    .load    (ph == PH_GATHER),
    .row     (row),
    .idx     (back_idx),
    .rd_data (back_rd)
  );

  cle_row_read u_cur_read (
    .clk     (clk),
    .load    (ph == PH_GATHER),
    .row     (row),
    .idx     (cur_idx),
    .rd_data (cur_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ph         <= PH_IDLE;
      elem_count <= '0;
      cur_ok     <= 1'b0;
      cur_idx    <= '0;
      st         <= cle_pkg::ST_OK;
      out_valid  <= 1'b0;
    end else begin
      case (ph)
        PH_IDLE: begin
          if (accept) begin
            elem_count <= elem_count_next;
            cur_ok     <= cur_ok_next;
            cur_idx    <= cur_idx_next;
            st         <= st_next;
            ph         <= PH_GATHER;
          end
        end
        PH_GATHER: begin
          ph <= PH_DRIVE;
        end
        PH_DRIVE: begin
          // hold until the output register is free
          if (out_free) ph <= PH_IDLE;
        end
        default: begin
          ph <= PH_IDLE;
        end
      endcase

      if (ph == PH_DRIVE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end

    if (ph == PH_DRIVE && out_free) begin
      status       <= st;
      front_value  <= empty ? '0 : row[0];
      back_value   <= empty ? '0 : back_rd;
      cursor_value <= cur_ok ? cur_rd : '1;
      count        <= elem_count;
      cursor_index <= cur_ok ? cur_ext : '1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cle_cell.sv
`default_nettype none

module cle_cell (
  input  wire logic                     clk,
  input  wire cle_pkg::shift_cmd_t      cmd,
  input  wire logic [cle_pkg::IDX_W-1:0] idx,
  input  wire cle_pkg::word_t           left,
  input  wire cle_pkg::word_t           right,
  output cle_pkg::word_t                data
);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (idx > cmd.at) begin
        data <= left;
      end else if (idx == cmd.at) begin
        data <= cmd.value;
      end
    end else if (cmd.del && idx >= cmd.at) begin
      data <= right;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cle_row_read.sv
`default_nettype none

module cle_row_read (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire cle_pkg::word_t            row [cle_pkg::CAPACITY],
  input  wire logic [cle_pkg::IDX_W-1:0] idx,
  output cle_pkg::word_t                 rd_data
);

  cle_pkg::word_t grp [cle_pkg::NGRP];

  // First level: pick the word at the low index bits inside each group
  for (genvar g = 0; g < cle_pkg::NGRP; g++) begin : g_grp
    always_ff @(posedge clk) begin
      if (load) begin
        grp[g] <= row[{cle_pkg::SEL_W'(g), idx[cle_pkg::GRP_W-1:0]}];
      end
    end
  end

  assign rd_data = grp[idx[cle_pkg::IDX_W-1:cle_pkg::GRP_W]];

endmodule

`default_nettype wire

>>> rtl/core/cle_checker.sv
`default_nettype none

module cle_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [1:0]                        status,
  input wire logic signed [cle_pkg::WORD_W-1:0] front_value,
  input wire logic signed [cle_pkg::WORD_W-1:0] back_value,
  input wire logic signed [cle_pkg::WORD_W-1:0] cursor_value,
  input wire logic [cle_pkg::CNT_W-1:0]         count,
  input wire logic signed [cle_pkg::CNT_W-1:0]  cursor_index
);

  // A word held by out_stall stays valid and keeps its status, count and cursor fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(count)
      && $stable(cursor_index) && $stable(cursor_value))
    else $error("stalled output word changed");

  // One word at a time: the block stalls right after taking a word
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous word in flight");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count <= cle_pkg::CNT_W'(cle_pkg::CAPACITY))
    else $error("count above capacity");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_index == -1) || ($unsigned(cursor_index) < count))
    else $error("cursor outside the list");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    out_valid && count == '0 |-> front_value == '0 && back_value == '0
      && cursor_index == -1 && status != 2'd3)
    else $error("empty list reports data");

endmodule

bind cursor_list_engine_unit cle_checker u_cle_checker (.*);

`default_nettype wire

>>> tb/cursor_list_engine_unit_tb.sv
module cursor_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_WORDS  = 200;
  localparam int RANDOM_BLOCKS = 4;
  localparam int IDLE_MAX      = 19;
  localparam int unsigned TIMEOUT_NS = 6_000_000;

  localparam logic [3:0] MODE_SPARE_LO = 4'd11;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;

  typedef struct {
    status_t                 st;
    word_t                   front;
    word_t                   back;
    word_t                   under;
    logic [CNT_W-1:0]        len;
    logic signed [CNT_W-1:0] at;
  } list_view_t;

  class list_tracker;
    word_t      row[$];
    int         cursor;
    list_view_t pending[$];
    int         errors;
    int         checked;
    int         longest;
    int         full_refusals;
    int         empty_refusals;

    function new();
      cursor = -1;
    endfunction

    function int length();
      return row.size();
    endfunction

    function int waiting();
      return pending.size();
    endfunction

    // Apply one accepted word to the shadow list and queue the view it leaves.
    function void note_word(logic [3:0] m, word_t v, logic [9:0] p);
      list_view_t view;
      bit empty;
      bit nocur;
      bit full;
      empty   = (row.size() == 0);
      nocur   = (cursor < 0);
      full    = (row.size() >= CAPACITY);
      view.st = ST_OK;
      case (m)
        MODE_CLEAR: begin
          row.delete();
          cursor = -1;
        end
        MODE_PREPEND: begin
          if (full) view.st = ST_FULL;
          else begin
            row.push_front(v);
            if (cursor >= 0) cursor++;
          end
        end
        MODE_APPEND: begin
          if (full) view.st = ST_FULL;
          else row.push_back(v);
        end
        MODE_INS_BEFORE: begin
          if (empty || nocur) view.st = ST_EMPTY;
          else if (full) view.st = ST_FULL;
          else begin
            row.insert(cursor, v);
            cursor++;
          end
        end
        MODE_INS_AFTER: begin
          // no cursor: drop silently with a clean status
          if (!(empty || nocur)) begin
            if (full) view.st = ST_FULL;
            else row.insert(cursor + 1, v);
          end
        end
        MODE_DEL_FRONT: begin
          if (empty) view.st = ST_EMPTY;
          else begin
            void'(row.pop_front());
            if (cursor >= 0) cursor--;
          end
        end
        MODE_DEL_BACK: begin
          if (empty) view.st = ST_EMPTY;
          else begin
            if (cursor == row.size() - 1) cursor = -1;
            void'(row.pop_back());
          end
        end
        MODE_DEL_CURSOR: begin
          if (empty || nocur) view.st = ST_EMPTY;
          else begin
            row.delete(cursor);
            cursor = -1;
          end
        end
        MODE_MOVE_TO: cursor = (int'(p) < row.size()) ? int'(p) : -1;
        MODE_PREV:    cursor = (cursor > 0 && cursor < row.size()) ? cursor - 1 : -1;
        MODE_NEXT:    cursor = (cursor >= 0 && cursor < row.size() - 1) ? cursor + 1 : -1;
        default: ;
      endcase
      view.front = (row.size() > 0) ? row[0] : '0;
      view.back  = (row.size() > 0) ? row[row.size() - 1] : '0;
      view.under = (cursor >= 0) ? row[cursor] : -32'sd1;
      view.len   = CNT_W'(row.size());
      view.at    = CNT_W'(cursor);
      if (row.size() > longest) longest = row.size();
      if (view.st == ST_FULL) full_refusals++;
      if (view.st == ST_EMPTY) empty_refusals++;
      pending.push_back(view);
    endfunction

    function bit field_ok(string fname, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(logic [1:0] st, word_t fv, word_t bv, word_t cv,
                               logic [CNT_W-1:0] n, logic signed [CNT_W-1:0] ci);
      list_view_t want;
      bit ok;
      if (pending.size() == 0) begin
        $display("%0t ns: result word with nothing pending, status %0d count %0d",
                 $time, st, n);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      ok = 1'b1;
      ok &= field_ok("status", 32'(want.st), 32'(st));
      ok &= field_ok("front_value", want.front, fv);
      ok &= field_ok("back_value", want.back, bv);
      ok &= field_ok("cursor_value", want.under, cv);
      ok &= field_ok("count", 32'(want.len), 32'(n));
      ok &= field_ok("cursor_index", 32'(want.at), 32'(ci));
      if (!ok) errors++;
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [3:0]              mode;
  word_t                   value;
  logic [9:0]              position;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              status;
  word_t                   front_value;
  word_t                   back_value;
  word_t                   cursor_value;
  logic [CNT_W-1:0]        count;
  logic signed [CNT_W-1:0] cursor_index;

  list_tracker tracker;
  int          send_gap_max = 0;
  int          recv_stall_max = 0;
  int          stall_left = 0;

  cursor_list_engine_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .value        (value),
    .position     (position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .front_value  (front_value),
    .back_value   (back_value),
    .cursor_value (cursor_value),
    .count        (count),
    .cursor_index (cursor_index)
  );

  always #(CLK_HALF) clk = ~clk;

  // Receiver: take a result word, then hold off for a random number of cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        tracker.check_result(status, front_value, back_value, cursor_value,
                             count, cursor_index);
        stall_left = $urandom_range(0, recv_stall_max);
      end else if (out_stall && stall_left > 0) begin
        stall_left = stall_left - 1;
      end
    end
  end

  always @(negedge clk) out_stall <= (stall_left > 0);

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return -32'sd1;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [3:0] m, input word_t v, input logic [9:0] p);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode     <= m;
    value    <= v;
    position <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    tracker.note_word(m, v, p);
    @(negedge clk);
  endtask

  task automatic drain_list();
    in_valid <= 1'b0;
    while (tracker.waiting() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_word(output bit counted);
    int         roll;
    int         len;
    logic [3:0] m;
    logic [9:0] p;
    len  = tracker.length();
    roll = $urandom_range(0, 99);
    if (roll < 2)       m = MODE_CLEAR;
    else if (roll < 10) m = MODE_PREPEND;
    else if (roll < 18) m = MODE_APPEND;
    else if (roll < 26) m = MODE_INS_BEFORE;
    else if (roll < 34) m = MODE_INS_AFTER;
    else if (roll < 40) m = MODE_DEL_FRONT;
    else if (roll < 46) m = MODE_DEL_BACK;
    else if (roll < 52) m = MODE_DEL_CURSOR;
    else if (roll < 66) m = MODE_MOVE_TO;
    else if (roll < 80) m = MODE_PREV;
    else if (roll < 95) m = MODE_NEXT;
    else                m = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    // re-aim a lost cursor most of the time so cursor work keeps landing
    if (tracker.cursor < 0 && len > 0 && $urandom_range(0, 2) != 0 &&
        m inside {MODE_INS_BEFORE, MODE_INS_AFTER, MODE_DEL_CURSOR, MODE_PREV, MODE_NEXT})
      m = MODE_MOVE_TO;
    if ($urandom_range(0, 6) == 0) p = 10'($urandom_range(0, 1023));
    else                           p = 10'($urandom_range(0, (len < 1023) ? len : 1023));
    counted = (m <= MODE_NEXT);
    send_word(m, pick_word(), p);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("cursor_list_engine_unit_tb: done, errors");
    $finish;
  end

  initial begin
    bit counted;
    int done_words;
    tracker  = new();
    rst      = 1'b1;
    in_valid = 1'b0;
    mode     = '0;
    value    = '0;
    position = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_gap_max   = IDLE_MAX;
    recv_stall_max = IDLE_MAX;

    // empty list: refusals, quiet insert-after, moves that find nothing
    send_word(MODE_DEL_FRONT, 32'sd5, '0);
    send_word(MODE_DEL_BACK, 32'sd5, '0);
    send_word(MODE_DEL_CURSOR, 32'sd5, '0);
    send_word(MODE_INS_BEFORE, 32'sd1, '0);
    send_word(MODE_INS_AFTER, 32'sd2, '0);
    send_word(MODE_PREV, '0, '0);
    send_word(MODE_NEXT, '0, '0);
    send_word(MODE_MOVE_TO, '0, '0);
    // filled list, cursor still undefined
    send_word(MODE_APPEND, 32'h7FFF_FFFF, '0);
    send_word(MODE_PREPEND, 32'h8000_0000, '0);
    send_word(MODE_INS_BEFORE, 32'h5555_5555, '0);
    send_word(MODE_INS_AFTER, 32'h5555_5555, '0);
    send_word(MODE_DEL_CURSOR, '0, '0);
    // cursor tracking through inserts, steps and deletes
    send_word(MODE_MOVE_TO, '0, 10'd1);
    send_word(MODE_PREPEND, -32'sd1, '0);
    send_word(MODE_INS_BEFORE, '0, '0);
    send_word(MODE_INS_AFTER, 32'hAAAA_AAAA, '0);
    send_word(MODE_NEXT, '0, '0);
    send_word(MODE_NEXT, '0, '0);
    send_word(MODE_MOVE_TO, '0, 10'd2);
    send_word(MODE_PREV, '0, '0);
    send_word(MODE_DEL_FRONT, '0, '0);
    send_word(MODE_DEL_FRONT, '0, '0);
    send_word(MODE_MOVE_TO, '0, 10'(tracker.length() - 1));
    send_word(MODE_DEL_BACK, '0, '0);
    send_word(MODE_MOVE_TO, '0, 10'h3FF);
    send_word(MODE_SPARE_LO, 32'h1234_5678, 10'h2AA);
    send_word(MODE_SPARE_HI, 32'h8765_4321, 10'h155);
    send_word(MODE_CLEAR, '0, '0);
    drain_list();

    // fill to capacity fast, then poke every insert at the limit
    send_gap_max   = 2;
    recv_stall_max = 2;
    repeat (CAPACITY) send_word(MODE_APPEND, pick_word(), '0);
    send_gap_max   = IDLE_MAX;
    recv_stall_max = IDLE_MAX;
    send_word(MODE_PREPEND, 32'sd7, '0);
    send_word(MODE_APPEND, 32'sd7, '0);
    send_word(MODE_INS_BEFORE, 32'sd7, '0);
    send_word(MODE_INS_AFTER, 32'sd7, '0);
    send_word(MODE_MOVE_TO, '0, 10'h3FF);
    send_word(MODE_INS_BEFORE, 32'sd7, '0);
    send_word(MODE_INS_AFTER, 32'sd7, '0);
    send_word(MODE_NEXT, '0, '0);
    send_word(MODE_MOVE_TO, '0, 10'h3FF);
    send_word(MODE_PREV, '0, '0);
    send_word(MODE_DEL_BACK, '0, '0);
    send_word(MODE_PREPEND, 32'h8000_0000, '0);
    send_word(MODE_DEL_CURSOR, '0, '0);
    send_word(MODE_APPEND, 32'h7FFF_FFFF, '0);
    send_word(MODE_CLEAR, '0, '0);
    drain_list();

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case (blk)
        0: begin send_gap_max = IDLE_MAX; recv_stall_max = IDLE_MAX; end
        1: begin send_gap_max = 0;        recv_stall_max = 0;        end
        2: begin send_gap_max = IDLE_MAX; recv_stall_max = 0;        end
        default: begin send_gap_max = 0;  recv_stall_max = IDLE_MAX; end
      endcase
      done_words = 0;
      while (done_words < RANDOM_WORDS / RANDOM_BLOCKS) begin
        send_random_word(counted);
        if (counted) done_words++;
      end
      // hold the sender until every pending result is back
      drain_list();
    end

    if (tracker.waiting() > 0) begin
      $display("%0t ns: %0d results never arrived", $time, tracker.waiting());
      tracker.errors++;
    end
    $display("list run: %0d result words checked, longest list %0d of %0d entries",
             tracker.checked, tracker.longest, CAPACITY);
    $display("refusals: %0d on empty list or lost cursor, %0d on full list",
             tracker.empty_refusals, tracker.full_refusals);
    if (tracker.errors == 0) begin
      $display("cursor_list_engine_unit_tb: done, clean");
    end else begin
      $display("cursor_list_engine_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cle_pkg.sv
rtl/core/cle_cell.sv
rtl/core/cle_row_read.sv
rtl/core/cursor_list_engine_unit.sv
rtl/core/cle_checker.sv
tb/cursor_list_engine_unit_tb.sv
